/* src/stepper_phase_sequencer_macros.svh */
// assertion helpers used by sps_core
`ifndef STEPPER_PHASE_SEQUENCER_MACROS_SVH
`define STEPPER_PHASE_SEQUENCER_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define SPS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked in the same cycle
`define SPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/sps_pkg.sv */
package sps_pkg;

  localparam int STEP_COUNT_BITS_DEF = 16;
  localparam int PERIOD_BITS_DEF     = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  // direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BWD  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE    = 2'd1;

  localparam logic [CFG_DATA_W-1:0] MIN_PERIOD_RST = 16'd100;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] goal_steps;
    logic [1:0]  move_direction;
    logic        speed_mode;
    logic [15:0] step_period;
  } in_item_t;

  typedef struct packed {
    logic [3:0] phase_pins;
    logic       moving;
    logic       at_position;
  } out_item_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] min_period;
    logic                  reverse_direction;
  } cfg_t;

  // full-step coil pattern, A..D in bits 3..0
  function automatic logic [3:0] full_step_row(input logic [1:0] idx);
    logic [3:0] row;
    unique case (idx)
      2'd0: row = 4'hA;
      2'd1: row = 4'h6;
      2'd2: row = 4'h5;
      default: row = 4'h9;
    endcase
    return row;
  endfunction

endpackage

/* src/sps_core.sv */
module sps_core #(
  parameter int STEP_COUNT_BITS = sps_pkg::STEP_COUNT_BITS_DEF,
  parameter int PERIOD_BITS     = sps_pkg::PERIOD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  sps_pkg::in_item_t item,
  input  sps_pkg::cfg_t     cfg,
  output sps_pkg::out_item_t result
);

  logic [1:0]                 phase_index_r, phase_index_nxt;
  logic [STEP_COUNT_BITS-1:0] steps_done_r, steps_done_nxt;
  logic [STEP_COUNT_BITS-1:0] goal_count_r, goal_count_nxt;
  logic                       run_mode_r, run_mode_nxt;
  logic [1:0]                 direction_state_r, direction_state_nxt;
  logic [PERIOD_BITS-1:0]     period_reload_r, period_reload_nxt;
  logic [PERIOD_BITS-1:0]     tick_count_r, tick_count_nxt;
  logic [3:0]                 pin_latch_r, pin_latch_nxt;
  logic                       goal_pending_r, goal_pending_nxt;

  logic [31:0]                goal_ext, per_ext, min_ext;
  logic [STEP_COUNT_BITS-1:0] goal;
  logic [PERIOD_BITS-1:0]     per, min_per;
  logic [1:0]                 dir_eff;

  assign goal_ext = {16'b0, item.goal_steps};
  assign per_ext  = {16'b0, item.step_period};
  assign min_ext  = {16'b0, cfg.min_period};
  assign goal     = goal_ext[STEP_COUNT_BITS-1:0];
  assign per      = per_ext[PERIOD_BITS-1:0];
  assign min_per  = min_ext[PERIOD_BITS-1:0];

  // polarity register swaps forward and backward
  always_comb begin
    dir_eff = direction_state_r;
    if (cfg.reverse_direction) begin
      if (direction_state_r == sps_pkg::DIR_FWD) begin
        dir_eff = sps_pkg::DIR_BWD;
      end else if (direction_state_r == sps_pkg::DIR_BWD) begin
        dir_eff = sps_pkg::DIR_FWD;
      end
    end
  end

  always_comb begin
    phase_index_nxt     = phase_index_r;
    steps_done_nxt      = steps_done_r;
    goal_count_nxt      = goal_count_r;
    run_mode_nxt        = run_mode_r;
    direction_state_nxt = direction_state_r;
    period_reload_nxt   = period_reload_r;
    tick_count_nxt      = tick_count_r;
    pin_latch_nxt       = pin_latch_r;
    goal_pending_nxt    = goal_pending_r;

    unique case (item.req_type)
      sps_pkg::REQ_TICK: begin
        if (period_reload_r != '0) begin
          if (tick_count_r >= period_reload_r) begin
            tick_count_nxt = '0;
            if ((steps_done_r < goal_count_r) || run_mode_r) begin
              if (dir_eff == sps_pkg::DIR_FWD) begin
                pin_latch_nxt   = sps_pkg::full_step_row(phase_index_r);
                phase_index_nxt = phase_index_r + 2'd1;
              end else if (dir_eff == sps_pkg::DIR_BWD) begin
                pin_latch_nxt   = sps_pkg::full_step_row(phase_index_r);
                phase_index_nxt = phase_index_r - 2'd1;
              end
              steps_done_nxt = steps_done_r + STEP_COUNT_BITS'(1);
            end else begin
              // goal reached: coils off and halt
              goal_pending_nxt    = 1'b0;
              direction_state_nxt = sps_pkg::DIR_NONE;
              pin_latch_nxt       = '0;
              period_reload_nxt   = '0;
            end
          end else begin
            tick_count_nxt = tick_count_r + PERIOD_BITS'(1);
          end
        end
      end
      sps_pkg::REQ_START: begin
        steps_done_nxt   = '0;
        tick_count_nxt   = '0;
        run_mode_nxt     = item.speed_mode;
        goal_count_nxt   = goal;
        goal_pending_nxt = !item.speed_mode && (goal != '0);
        if (per == '0) begin
          goal_pending_nxt    = 1'b0;
          direction_state_nxt = sps_pkg::DIR_NONE;
          pin_latch_nxt       = '0;
          period_reload_nxt   = '0;
        end else begin
          period_reload_nxt   = (per < min_per) ? min_per : per;
          direction_state_nxt = item.move_direction;
        end
      end
      sps_pkg::REQ_STOP: begin
        direction_state_nxt = sps_pkg::DIR_NONE;
        pin_latch_nxt       = '0;
        period_reload_nxt   = '0;
        tick_count_nxt      = '0;
      end
      default: begin
        // unused request code leaves the state alone
        tick_count_nxt = tick_count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_index_r     <= '0;
      steps_done_r      <= '0;
      goal_count_r      <= '0;
      run_mode_r        <= 1'b0;
      direction_state_r <= sps_pkg::DIR_NONE;
      period_reload_r   <= '0;
      tick_count_r      <= '0;
      pin_latch_r       <= '0;
      goal_pending_r    <= 1'b0;
    end else if (advance) begin
      phase_index_r     <= phase_index_nxt;
      steps_done_r      <= steps_done_nxt;
      goal_count_r      <= goal_count_nxt;
      run_mode_r        <= run_mode_nxt;
      direction_state_r <= direction_state_nxt;
      period_reload_r   <= period_reload_nxt;
      tick_count_r      <= tick_count_nxt;
      pin_latch_r       <= pin_latch_nxt;
      goal_pending_r    <= goal_pending_nxt;
    end
  end

  // result reflects the state after this beat
  assign result.phase_pins  = pin_latch_nxt;
  assign result.moving      = (direction_state_nxt != sps_pkg::DIR_NONE)
                              && (period_reload_nxt != '0);
  assign result.at_position = !goal_pending_nxt;

`include "stepper_phase_sequencer_macros.svh"

  `SPS_ASSERT_IMPL(a_halt_no_dir, period_reload_r == '0, direction_state_r == sps_pkg::DIR_NONE, "direction set while halted")
  `SPS_ASSERT_IMPL(a_halt_coils_off, period_reload_r == '0, pin_latch_r == '0, "coils on while halted")
  `SPS_ASSERT_ALWAYS(a_tick_bound, tick_count_r <= period_reload_r, "tick count beyond period")

endmodule

/* src/stepper_phase_sequencer.sv */
// channel  | direction | handshake            | payload
// in_      | input     | in_valid / in_stall  | sps_pkg::in_item_t
// out_     | output    | out_valid / out_stall| sps_pkg::out_item_t
// cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one beat per cycle sustained while out_stall is low; a taken beat passes
// the input register, then the state update into the result register
// the state registers and their update loop set this rate
// synchronous active-low reset clears the motor state, config goes to defaults
// a stalled result holds while one more input beat waits in the input register
module stepper_phase_sequencer #(
  parameter int STEP_COUNT_BITS = sps_pkg::STEP_COUNT_BITS_DEF,
  parameter int PERIOD_BITS     = sps_pkg::PERIOD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sps_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sps_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sps_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic               in_valid_r, in_valid_nxt;
  sps_pkg::in_item_t  in_data_r;
  logic               out_valid_r, out_valid_nxt;
  sps_pkg::out_item_t out_data_r;
  sps_pkg::out_item_t core_result;
  sps_pkg::cfg_t      cfg_r, cfg_nxt;
  logic               advance;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_valid_nxt = in_stall ? in_valid_r : in_valid;
    priority if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == sps_pkg::CFG_MIN_PERIOD) begin
        cfg_nxt.min_period = cfg_data;
      end else if (cfg_index == sps_pkg::CFG_REVERSE) begin
        cfg_nxt.reverse_direction = cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r.min_period        <= sps_pkg::MIN_PERIOD_RST;
      cfg_r.reverse_direction <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= core_result;
    end
  end

  sps_core #(
    .STEP_COUNT_BITS(STEP_COUNT_BITS),
    .PERIOD_BITS    (PERIOD_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(advance),
    .item   (in_data_r),
    .cfg    (cfg_r),
    .result (core_result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
